// File: rtl/pcr_pkg.sv
// pcr_pkg: shared types and constants of the packet chunk reassembler
// request and result structs, status codes, store geometry
// no dependencies
package pcr_pkg;

  localparam int MAX_CHUNKS  = 16;
  localparam int CHUNK_BYTES = 256;
  localparam int OFF_W       = $clog2(CHUNK_BYTES);
  localparam int SLOT_W      = $clog2(MAX_CHUNKS);
  localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);
  // one spare page beyond the slots serves as staging area
  localparam int PAGES       = MAX_CHUNKS + 1;
  localparam int PAGE_W      = $clog2(PAGES);
  localparam int RAM_DEPTH   = PAGES * CHUNK_BYTES;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int HDR_BYTES   = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
  localparam logic [7:0] RESET_OWN_ADDR = 8'd187;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_BCAST   = 1'd1;

  localparam logic [2:0] HDR_RCPT  = 3'd0;
  localparam logic [2:0] HDR_SRC   = 3'd1;
  localparam logic [2:0] HDR_ID    = 3'd2;
  localparam logic [2:0] HDR_TOTAL = 3'd3;
  localparam logic [2:0] HDR_IDX   = 3'd4;
  localparam logic [2:0] HDR_PLEN  = 3'd5;

  typedef enum logic [3:0] {
    ST_STORED   = 4'd0,
    ST_COMPLETE = 4'd1,
    ST_SHORT    = 4'd2,
    ST_LENGTH   = 4'd3,
    ST_NOT_ME   = 4'd4,
    ST_IGNORED  = 4'd5,
    ST_TOO_MANY = 4'd6,
    ST_DRAIN    = 4'd7,
    ST_EMPTY    = 4'd8
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  message_byte;
    logic        last_of_message;
    logic [7:0]  source_address;
    logic [7:0]  msg_ident;
    logic [11:0] message_length;
  } result_t;

endpackage

// File: rtl/packet_chunk_reassembler_unit.sv
// a result passes the result stage (ram read) and the result queue before it leaves
// throughput: one request per cycle unless item_stall holds it; payload bytes write
// straight into a spare staging page of the chunk ram, and an accepted chunk swaps that page
// into the slot map. drain requests read the ram one byte per cycle, also unless stalled
// reset (rst, synchronous) clears header position, tracker, slot map and queue; ram
// contents stay undefined and are never read before written. no clearing pass.
module packet_chunk_reassembler_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  pcr_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output pcr_pkg::result_t                  result
);

  localparam int MC = pcr_pkg::MAX_CHUNKS;

  // configuration
  logic [7:0] own_address;
  logic       accept_broadcast;

  // packet parsing
  logic [2:0] hpos, hpos_next;
  logic [7:0] hdr [pcr_pkg::HDR_BYTES];
  logic [8:0] staged, staged_next;

  // tracker
  logic                     active, active_next;
  logic [7:0]               tid, tid_next;
  logic [7:0]               ttot, ttot_next;
  logic [7:0]               rcvd, rcvd_next;
  logic [7:0]               lens [MC];
  logic [pcr_pkg::PAGE_W-1:0] pmap [MC];
  logic [pcr_pkg::PAGE_W-1:0] free_page, free_page_next;
  logic [11:0]              sum, sum_next;
  logic                     ready, ready_next;
  logic [pcr_pkg::CNT_W-1:0] dchunk, dchunk_next;
  logic [pcr_pkg::OFF_W-1:0] doff, doff_next;
  logic                     slot_we;
  logic [pcr_pkg::SLOT_W-1:0] slot_idx;

  // result path
  logic             s1_valid;
  logic             s1_drain;
  pcr_pkg::result_t s1_res;
  pcr_pkg::result_t s1_out;
  logic             push;
  pcr_pkg::result_t res_next;
  pcr_pkg::result_t q [3];
  logic [1:0]       wp, rp, qcount;

  // ram
  logic                      ram_we;
  logic [pcr_pkg::RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]                ram_rdata;

  logic acc;
  logic pop;

  // per-request working values
  logic [7:0]               heff [pcr_pkg::HDR_BYTES];
  logic [8:0]               count_eff;
  logic                     restart;
  logic                     act_e;
  logic [7:0]               tid_e, ttot_e;
  logic [11:0]              sum_base, old_len, sum_new;
  logic [7:0]               rcvd_new;
  logic [MC-1:0]            filled;
  logic [pcr_pkg::CNT_W-1:0] c, c_after;
  logic [pcr_pkg::SLOT_W-1:0] cs;
  logic [8:0]               off_inc;
  logic [pcr_pkg::OFF_W-1:0] off_use;

  function automatic logic [pcr_pkg::CNT_W-1:0] next_filled(
    input logic [MC-1:0]            mask,
    input logic [pcr_pkg::CNT_W-1:0] from,
    input logic [7:0]               tot
  );
    logic [pcr_pkg::CNT_W-1:0] r;
    r = pcr_pkg::CNT_W'(tot);
    for (int j = MC - 1; j >= 0; j--) begin
      if (mask[j] && (pcr_pkg::CNT_W'(j) >= from)) begin
        r = pcr_pkg::CNT_W'(j);
      end
    end
    return r;
  endfunction

  assign acc          = item_valid && !item_stall;
  assign pop          = result_valid && !result_stall;
  assign item_stall   = (3'(qcount) + 3'(s1_valid)) >= 3'd3;
  assign result_valid = (qcount != 2'd0);
  assign result       = q[rp];

  always_comb begin
    for (int j = 0; j < MC; j++) begin
      filled[j] = (lens[j] != 8'd0) && (8'(j) < ttot);
    end
  end

  pcr_ram #(
    .WIDTH(8),
    .DEPTH(pcr_pkg::RAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(item.data_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    hpos_next      = hpos;
    staged_next    = staged;
    active_next    = active;
    tid_next       = tid;
    ttot_next      = ttot;
    rcvd_next      = rcvd;
    free_page_next = free_page;
    sum_next       = sum;
    ready_next     = ready;
    dchunk_next    = dchunk;
    doff_next      = doff;
    slot_we        = 1'b0;
    restart        = 1'b0;
    push           = 1'b0;
    res_next       = '0;
    ram_we         = 1'b0;
    ram_waddr      = {free_page, staged[pcr_pkg::OFF_W-1:0]};

    for (int k = 0; k < pcr_pkg::HDR_BYTES; k++) begin
      heff[k] = (hpos == 3'(k)) ? item.data_byte : hdr[k];
    end
    slot_idx  = heff[pcr_pkg::HDR_IDX][pcr_pkg::SLOT_W-1:0];
    if (hpos < 3'(pcr_pkg::HDR_BYTES)) begin
      count_eff = staged;
    end else begin
      count_eff = (staged != 9'd511) ? staged + 9'd1 : staged;
    end
    restart  = (heff[pcr_pkg::HDR_IDX] == 8'd0);
    act_e    = restart ? 1'b1 : active;
    tid_e    = restart ? heff[pcr_pkg::HDR_ID] : tid;
    ttot_e   = restart ? heff[pcr_pkg::HDR_TOTAL] : ttot;
    sum_base = restart ? 12'd0 : sum;
    old_len  = restart ? 12'd0 : 12'(lens[slot_idx]);
    sum_new  = sum_base - old_len + 12'(heff[pcr_pkg::HDR_PLEN]);
    rcvd_new = (restart ? 8'd0 : rcvd) + 8'd1;

    // drain side
    c       = next_filled(filled, dchunk, ttot);
    cs      = c[pcr_pkg::SLOT_W-1:0];
    off_use = (c != dchunk) ? '0 : doff;
    off_inc = 9'(off_use) + 9'd1;
    c_after = c;
    ram_raddr = {pmap[cs], off_use};

    if (acc && !item.kind) begin
      if (hpos < 3'(pcr_pkg::HDR_BYTES)) begin
        hpos_next = hpos + 3'd1;
      end else begin
        ram_we = (staged < 9'(pcr_pkg::CHUNK_BYTES));
        if (staged != 9'd511) begin
          staged_next = staged + 9'd1;
        end
      end
      if (item.end_of_packet) begin
        hpos_next   = '0;
        staged_next = '0;
        push        = 1'b1;
        res_next.source_address = heff[pcr_pkg::HDR_SRC];
        res_next.msg_ident      = heff[pcr_pkg::HDR_ID];
        if (hpos < 3'(pcr_pkg::HDR_BYTES - 1)) begin
          res_next.status         = pcr_pkg::ST_SHORT;
          res_next.source_address = '0;
          res_next.msg_ident      = '0;
        end else if (count_eff != 9'(heff[pcr_pkg::HDR_PLEN])
                     || 9'(heff[pcr_pkg::HDR_PLEN]) > 9'(pcr_pkg::CHUNK_BYTES)) begin
          res_next.status = pcr_pkg::ST_LENGTH;
        end else if (!(heff[pcr_pkg::HDR_RCPT] == own_address
                       || (accept_broadcast
                           && heff[pcr_pkg::HDR_RCPT] == pcr_pkg::BROADCAST_ADDR))) begin
          res_next.status = pcr_pkg::ST_NOT_ME;
        end else if (heff[pcr_pkg::HDR_TOTAL] > 8'(MC)) begin
          res_next.status = pcr_pkg::ST_TOO_MANY;
        end else begin
          if (restart) begin
            active_next = 1'b1;
            tid_next    = tid_e;
            ttot_next   = ttot_e;
            rcvd_next   = '0;
            sum_next    = '0;
            ready_next  = 1'b0;
            dchunk_next = '0;
            doff_next   = '0;
          end
          if (!act_e || tid_e != heff[pcr_pkg::HDR_ID] || heff[pcr_pkg::HDR_IDX] >= ttot_e
              || heff[pcr_pkg::HDR_IDX] >= 8'(MC)) begin
            res_next.status = pcr_pkg::ST_IGNORED;
          end else begin
            // staging page becomes the slot, the slot's old page is the new staging area
            slot_we        = 1'b1;
            free_page_next = pmap[slot_idx];
            sum_next       = sum_new;
            rcvd_next      = rcvd_new;
            if (rcvd_new == ttot_e) begin
              active_next             = 1'b0;
              ready_next              = 1'b1;
              dchunk_next             = '0;
              doff_next               = '0;
              res_next.status         = pcr_pkg::ST_COMPLETE;
              res_next.message_length = sum_new;
            end else begin
              res_next.status = pcr_pkg::ST_STORED;
            end
          end
        end
      end
    end else if (acc && item.kind) begin
      push            = 1'b1;
      res_next.status = pcr_pkg::ST_EMPTY;
      if (ready) begin
        if (9'(c) >= 9'(ttot)) begin
          ready_next = 1'b0;
        end else begin
          if (off_inc >= 9'(lens[cs])) begin
            c_after   = c + 1'b1;
            doff_next = '0;
          end else begin
            doff_next = off_inc[pcr_pkg::OFF_W-1:0];
          end
          dchunk_next = c_after;
          res_next.status          = pcr_pkg::ST_DRAIN;
          res_next.msg_ident       = tid;
          res_next.message_length  = sum;
          res_next.last_of_message =
            9'(next_filled(filled, c_after, ttot)) >= 9'(ttot);
          if (res_next.last_of_message) begin
            ready_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address      <= pcr_pkg::RESET_OWN_ADDR;
      accept_broadcast <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        pcr_pkg::CFG_OWN_ADDRESS:  own_address      <= cfg_data;
        pcr_pkg::CFG_ACCEPT_BCAST: accept_broadcast <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hpos      <= '0;
      staged    <= '0;
      active    <= 1'b0;
      tid       <= '0;
      ttot      <= '0;
      rcvd      <= '0;
      free_page <= pcr_pkg::PAGE_W'(MC);
      sum       <= '0;
      ready     <= 1'b0;
      dchunk    <= '0;
      doff      <= '0;
      for (int j = 0; j < MC; j++) begin
        lens[j] <= '0;
        pmap[j] <= pcr_pkg::PAGE_W'(j);
      end
    end else begin
      hpos      <= hpos_next;
      staged    <= staged_next;
      active    <= active_next;
      tid       <= tid_next;
      ttot      <= ttot_next;
      rcvd      <= rcvd_next;
      free_page <= free_page_next;
      sum       <= sum_next;
      ready     <= ready_next;
      dchunk    <= dchunk_next;
      doff      <= doff_next;
      // the stored slot takes its length, a restart clears all others
      for (int j = 0; j < MC; j++) begin
        if (slot_we && slot_idx == pcr_pkg::SLOT_W'(j)) begin
          lens[j] <= heff[pcr_pkg::HDR_PLEN];
        end else if (restart && acc && !item.kind && item.end_of_packet
                     && res_next.status != pcr_pkg::ST_SHORT
                     && res_next.status != pcr_pkg::ST_LENGTH
                     && res_next.status != pcr_pkg::ST_NOT_ME
                     && res_next.status != pcr_pkg::ST_TOO_MANY) begin
          lens[j] <= '0;
        end
      end
      if (slot_we) begin
        pmap[slot_idx] <= free_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !item.kind && hpos < 3'(pcr_pkg::HDR_BYTES)) begin
      hdr[hpos] <= item.data_byte;
    end
  end

  // result stage while the ram read is in flight, then a three-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wp       <= '0;
      rp       <= '0;
      qcount   <= '0;
    end else begin
      s1_valid <= push;
      if (s1_valid) begin
        wp <= (wp == 2'd2) ? 2'd0 : wp + 2'd1;
      end
      if (pop) begin
        rp <= (rp == 2'd2) ? 2'd0 : rp + 2'd1;
      end
      qcount <= qcount + 2'(s1_valid) - 2'(pop);
    end
  end

  always_comb begin
    s1_out              = s1_res;
    s1_out.message_byte = s1_drain ? ram_rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    s1_res   <= res_next;
    s1_drain <= (res_next.status == pcr_pkg::ST_DRAIN);
    if (s1_valid) begin
      q[wp] <= s1_out;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qcount == 2'd3 |-> !s1_valid)
    else $error("result queue overflow");

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(ready && active))
    else $error("message ready while tracker active");

  a_drain_flow: assert property (@(posedge clk) disable iff (rst)
    acc && item.kind |=> s1_valid)
    else $error("drain request gave no result");

  a_free_page: assert property (@(posedge clk) disable iff (rst)
    slot_we |=> pmap[$past(slot_idx)] != free_page)
    else $error("staging page still mapped");

endmodule

// File: rtl/pcr_ram.sv
// pcr_ram: generic single write, single read port ram with registered read
// no dependencies
module pcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
